FILE: design/grid_walk_coverage_tracker_macros.svh
// Assertion macros for the grid walk coverage tracker.
// Included by the top level; no other dependencies.
`ifndef GRID_WALK_COVERAGE_TRACKER_MACROS_SVH
`define GRID_WALK_COVERAGE_TRACKER_MACROS_SVH

// Condition must never hold while out of reset
`define GWCT_ASSERT_NEVER(lbl, clk, rst_n, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) !(cond)) else $error(msg);

// Antecedent in one cycle implies consequent in the next
`define GWCT_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: design/gwct_pkg.sv
// Shared types, constants and helpers for the grid walk coverage tracker.
// No dependencies.
package gwct_pkg;

    localparam int MAX_HALF = 64;
    localparam int SIDE     = 2 * MAX_HALF - 1;
    localparam int COORD_W  = $clog2(2 * MAX_HALF);
    localparam int ADDR_W   = 2 * COORD_W;
    localparam int DEPTH    = 1 << ADDR_W;
    localparam int HALF_W   = 7;
    localparam int POS_W    = 8;
    localparam int CNT_W    = 14;
    localparam int DIR_W    = 2;

    typedef enum logic [DIR_W-1:0] {
        DIR_Y_UP = 2'd0,
        DIR_X_UP = 2'd1,
        DIR_Y_DN = 2'd2,
        DIR_X_DN = 2'd3
    } t_dir;

    // Write request into the visited map
    typedef struct packed {
        logic              en;
        logic [ADDR_W-1:0] addr;
        logic              data;
    } t_map_wr;

    // Clamp the register to 1..MAX_HALF
    function automatic logic [HALF_W-1:0] eff_half(input logic [HALF_W-1:0] h);
        logic [HALF_W-1:0] n;
        n = h;
        if (h == '0) begin
            n = HALF_W'(1);
        end else if (h > HALF_W'(MAX_HALF)) begin
            n = HALF_W'(MAX_HALF);
        end
        return n;
    endfunction

    // Strictly inside the square of half-width n
    function automatic logic in_box(input logic signed [POS_W-1:0] x,
                                    input logic signed [POS_W-1:0] y,
                                    input logic [HALF_W-1:0] n);
        logic signed [POS_W-1:0] pn;
        logic signed [POS_W-1:0] nn;
        pn = signed'(POS_W'(n));
        nn = -pn;
        return (x > nn) && (x < pn) && (y > nn) && (y < pn);
    endfunction

    // Map address: offset coordinates concatenated, no multiply
    function automatic logic [ADDR_W-1:0] map_addr(input logic signed [POS_W-1:0] x,
                                                   input logic signed [POS_W-1:0] y);
        logic [POS_W-1:0] ix;
        logic [POS_W-1:0] iy;
        ix = POS_W'(x + POS_W'(MAX_HALF - 1));
        iy = POS_W'(y + POS_W'(MAX_HALF - 1));
        return {ix[COORD_W-1:0], iy[COORD_W-1:0]};
    endfunction

endpackage

FILE: design/gwct_step_if.sv
// Step request channel: valid/ready with a direction payload.
// Depends on gwct_pkg.
interface gwct_step_if;
    logic                         valid;
    logic                         ready;
    logic [gwct_pkg::DIR_W-1:0]   direction;

    modport source (output valid, output direction, input ready);
    modport sink   (input valid, input direction, output ready);
endinterface

FILE: design/gwct_result_if.sv
// Result request channel: valid/ready with visited and grid cell counts.
// Depends on gwct_pkg.
interface gwct_result_if;
    logic                         valid;
    logic                         ready;
    logic [gwct_pkg::CNT_W-1:0]   visited_cells;
    logic [gwct_pkg::CNT_W-1:0]   grid_cells;

    modport source (output valid, output visited_cells, output grid_cells, input ready);
    modport sink   (input valid, input visited_cells, input grid_cells, output ready);
endinterface

FILE: design/grid_walk_coverage_tracker.sv
// Grid walk coverage tracker: a step runs as accept + map read, then mark and move,
// bound by the read-modify-write of the visited map through its registered read port.
// An escaping step loads the result register once the output slot is free, then the
// map is swept clean, one bit a cycle, with no step accepted meanwhile.
// Synchronous active-low reset starts the same sweep; half_size resets to 64.
// Depends on gwct_pkg, gwct_step_if, gwct_result_if, gwct_vmap and the macros.
`include "grid_walk_coverage_tracker_macros.svh"

module grid_walk_coverage_tracker (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_wr_en,
    input  logic [gwct_pkg::HALF_W-1:0]   i_cfg_wr_data,
    gwct_step_if.sink                     i_step,
    gwct_result_if.source                 o_result
);

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_EXEC,
        ST_EMIT
    } t_state;

    t_state                               r_state, n_state;
    logic [gwct_pkg::HALF_W-1:0]          r_half;
    logic signed [gwct_pkg::POS_W-1:0]    r_pos_x, n_pos_x;
    logic signed [gwct_pkg::POS_W-1:0]    r_pos_y, n_pos_y;
    logic [gwct_pkg::CNT_W-1:0]           r_visited, n_visited;
    logic [gwct_pkg::DIR_W-1:0]           r_dir;
    logic [gwct_pkg::ADDR_W-1:0]          r_clr_addr, n_clr_addr;
    logic [gwct_pkg::CNT_W-1:0]           r_res_visited, n_res_visited;
    logic [gwct_pkg::CNT_W-1:0]           r_res_grid, n_res_grid;
    logic                                 r_out_valid, n_out_valid;
    logic [gwct_pkg::CNT_W-1:0]           r_out_visited, n_out_visited;
    logic [gwct_pkg::CNT_W-1:0]           r_out_grid, n_out_grid;

    gwct_pkg::t_map_wr                    w_map_wr;
    logic                                 w_rd_bit;
    logic                                 w_accept;
    logic                                 w_slot_free;
    logic [gwct_pkg::HALF_W-1:0]          w_n;
    logic [gwct_pkg::HALF_W-1:0]          w_side;
    logic [gwct_pkg::CNT_W-1:0]           w_grid;
    logic signed [gwct_pkg::POS_W-1:0]    w_mx, w_my;
    logic [gwct_pkg::CNT_W-1:0]           w_cnt_mark;

    gwct_vmap u_vmap (
        .i_clk     (i_clk),
        .i_wr      (w_map_wr),
        .i_rd_addr (gwct_pkg::map_addr(r_pos_x, r_pos_y)),
        .o_rd_data (w_rd_bit)
    );

    assign i_step.ready           = (r_state == ST_IDLE);
    assign w_accept               = i_step.valid && i_step.ready;
    assign w_slot_free            = !r_out_valid || o_result.ready;
    assign o_result.valid         = r_out_valid;
    assign o_result.visited_cells = r_out_visited;
    assign o_result.grid_cells    = r_out_grid;

    // Effective half-width and interior cell count
    assign w_n    = gwct_pkg::eff_half(r_half);
    assign w_side = gwct_pkg::HALF_W'({w_n, 1'b0} - (gwct_pkg::HALF_W + 1)'(1));
    assign w_grid = gwct_pkg::CNT_W'(w_side) * gwct_pkg::CNT_W'(w_side);

    // Count after marking the current cell
    assign w_cnt_mark = w_rd_bit ? r_visited : r_visited + gwct_pkg::CNT_W'(1);

    // Position after the move
    always_comb begin
        w_mx = r_pos_x;
        w_my = r_pos_y;
        unique case (gwct_pkg::t_dir'(r_dir))
            gwct_pkg::DIR_Y_UP: w_my = r_pos_y + gwct_pkg::POS_W'(1);
            gwct_pkg::DIR_X_UP: w_mx = r_pos_x + gwct_pkg::POS_W'(1);
            gwct_pkg::DIR_Y_DN: w_my = r_pos_y - gwct_pkg::POS_W'(1);
            gwct_pkg::DIR_X_DN: w_mx = r_pos_x - gwct_pkg::POS_W'(1);
        endcase
    end

    // Sequencer next state
    always_comb begin
        n_state       = r_state;
        n_pos_x       = r_pos_x;
        n_pos_y       = r_pos_y;
        n_visited     = r_visited;
        n_clr_addr    = r_clr_addr;
        n_res_visited = r_res_visited;
        n_res_grid    = r_res_grid;
        n_out_valid   = r_out_valid && !o_result.ready;
        n_out_visited = r_out_visited;
        n_out_grid    = r_out_grid;
        w_map_wr      = '{en: 1'b0, addr: gwct_pkg::map_addr(r_pos_x, r_pos_y), data: 1'b1};

        unique case (r_state)
            ST_CLEAR: begin
                w_map_wr   = '{en: 1'b1, addr: r_clr_addr, data: 1'b0};
                n_clr_addr = r_clr_addr + gwct_pkg::ADDR_W'(1);
                if (&r_clr_addr) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (w_accept) begin
                    n_state = ST_EXEC;
                end
            end
            ST_EXEC: begin
                n_res_grid = w_grid;
                if (!gwct_pkg::in_box(r_pos_x, r_pos_y, w_n)) begin
                    // walker left stranded by a lowered half-size
                    n_res_visited = r_visited;
                    n_state       = ST_EMIT;
                end else begin
                    w_map_wr.en   = !w_rd_bit;
                    n_visited     = w_cnt_mark;
                    n_res_visited = w_cnt_mark;
                    n_pos_x       = w_mx;
                    n_pos_y       = w_my;
                    n_state       = gwct_pkg::in_box(w_mx, w_my, w_n) ? ST_IDLE : ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (w_slot_free) begin
                    n_out_valid   = 1'b1;
                    n_out_visited = r_res_visited;
                    n_out_grid    = r_res_grid;
                    n_pos_x       = '0;
                    n_pos_y       = '0;
                    n_visited     = '0;
                    n_clr_addr    = '0;
                    n_state       = ST_CLEAR;
                end
            end
            default: n_state = ST_CLEAR;
        endcase
    end

    // State and registered outputs
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_CLEAR;
            r_half      <= gwct_pkg::HALF_W'(gwct_pkg::MAX_HALF);
            r_pos_x     <= '0;
            r_pos_y     <= '0;
            r_visited   <= '0;
            r_clr_addr  <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_pos_x     <= n_pos_x;
            r_pos_y     <= n_pos_y;
            r_visited   <= n_visited;
            r_clr_addr  <= n_clr_addr;
            r_out_valid <= n_out_valid;
            if (i_cfg_wr_en) begin
                r_half <= i_cfg_wr_data;
            end
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_dir <= i_step.direction;
        end
        r_res_visited <= n_res_visited;
        r_res_grid    <= n_res_grid;
        r_out_visited <= n_out_visited;
        r_out_grid    <= n_out_grid;
    end

    // Checks
    `GWCT_ASSERT_NEVER(a_pos_range, i_clk, i_rst_n, (r_pos_x > 8'sd64) || (r_pos_x < -8'sd64) || (r_pos_y > 8'sd64) || (r_pos_y < -8'sd64), "walker outside map range")
    `GWCT_ASSERT_NEXT(a_emit_restart, i_clk, i_rst_n, (r_state == ST_EMIT) && w_slot_free, (r_state == ST_CLEAR) && (r_clr_addr == '0) && (r_visited == '0) && r_out_valid, "escape did not restart walk")
    `GWCT_ASSERT_NEVER(a_write_in_idle, i_clk, i_rst_n, w_map_wr.en && ((r_state == ST_IDLE) || (r_state == ST_EMIT)), "map written outside exec or sweep")

endmodule

FILE: design/gwct_vmap.sv
// Visited map: one bit per grid cell, one write and one registered read port.
// Depends on gwct_pkg.
module gwct_vmap (
    input  logic                          i_clk,
    input  gwct_pkg::t_map_wr             i_wr,
    input  logic [gwct_pkg::ADDR_W-1:0]   i_rd_addr,
    output logic                          o_rd_data
);

    logic r_mem [gwct_pkg::DEPTH];
    logic r_rd_data;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            r_mem[i_wr.addr] <= i_wr.data;
        end
    end

    // Registered read port
    always_ff @(posedge i_clk) begin
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

FILE: bench/grid_walk_coverage_tracker_tb.sv
// Self-checking bench for grid_walk_coverage_tracker: drives step requests, predicts
// escape reports with its own walk model and checks every report field by field.
// Depends on gwct_pkg, gwct_step_if, gwct_result_if and the tracker RTL.
`timescale 1ns / 100ps

module grid_walk_coverage_tracker_tb;

    localparam int SWEEP_CYCLES   = 16384;
    localparam int WATCHDOG_LIMIT = 60000;
    localparam int END_SETTLE     = 64;
    localparam int STEP_TARGET    = 520;
    localparam int WALK_TARGET    = 40;
    localparam int WALK_CAP       = 52;
    localparam int PLAN_ROWS      = 25;

    typedef enum logic { ROW_STEP, ROW_CFG } t_row_kind;
    typedef enum int { IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH } t_idle_mode;

    typedef struct packed {
        logic [gwct_pkg::CNT_W-1:0] visited;
        logic [gwct_pkg::CNT_W-1:0] grid;
    } t_walk_report;

    typedef struct packed {
        t_row_kind                   kind;
        logic [gwct_pkg::HALF_W-1:0] half;
        gwct_pkg::t_dir              dir;
        logic                        typed;
        logic [gwct_pkg::CNT_W-1:0]  want_visited;
        logic [gwct_pkg::CNT_W-1:0]  want_grid;
    } t_walk_row;

    // Directed walks: typed reports only where the count is obvious
    localparam t_walk_row DIRECTED_PLAN [0:PLAN_ROWS-1] = '{
        // square loop back to the origin at full size, four cells marked
        '{ROW_STEP, 7'd0,   gwct_pkg::DIR_Y_UP, 1'b0, 14'd0, 14'd0},
        '{ROW_STEP, 7'd0,   gwct_pkg::DIR_X_UP, 1'b0, 14'd0, 14'd0},
        '{ROW_STEP, 7'd0,   gwct_pkg::DIR_Y_DN, 1'b0, 14'd0, 14'd0},
        '{ROW_STEP, 7'd0,   gwct_pkg::DIR_X_DN, 1'b0, 14'd0, 14'd0},
        // half-width one: every step escapes
        '{ROW_CFG,  7'd1,   gwct_pkg::DIR_Y_UP, 1'b0, 14'd0, 14'd0},
        '{ROW_STEP, 7'd0,   gwct_pkg::DIR_Y_UP, 1'b1, 14'd4, 14'd1},
        '{ROW_STEP, 7'd0,   gwct_pkg::DIR_X_DN, 1'b1, 14'd1, 14'd1},
        // zero acts as one
        '{ROW_CFG,  7'd0,   gwct_pkg::DIR_Y_UP, 1'b0, 14'd0, 14'd0},
        '{ROW_STEP, 7'd0,   gwct_pkg::DIR_Y_DN, 1'b1, 14'd1, 14'd1},
        '{ROW_STEP, 7'd0,   gwct_pkg::DIR_X_UP, 1'b1, 14'd1, 14'd1},
        // all ones saturates to full size; walk three cells right
        '{ROW_CFG,  7'd127, gwct_pkg::DIR_Y_UP, 1'b0, 14'd0, 14'd0},
        '{ROW_STEP, 7'd0,   gwct_pkg::DIR_X_UP, 1'b0, 14'd0, 14'd0},
        '{ROW_STEP, 7'd0,   gwct_pkg::DIR_X_UP, 1'b0, 14'd0, 14'd0},
        '{ROW_STEP, 7'd0,   gwct_pkg::DIR_X_UP, 1'b0, 14'd0, 14'd0},
        // shrink under the walker: next step reports without moving
        '{ROW_CFG,  7'd2,   gwct_pkg::DIR_Y_UP, 1'b0, 14'd0, 14'd0},
        '{ROW_STEP, 7'd0,   gwct_pkg::DIR_Y_UP, 1'b1, 14'd3, 14'd9},
        '{ROW_STEP, 7'd0,   gwct_pkg::DIR_Y_UP, 1'b0, 14'd0, 14'd0},
        '{ROW_STEP, 7'd0,   gwct_pkg::DIR_Y_UP, 1'b1, 14'd2, 14'd9},
        // straight escapes through the low borders
        '{ROW_CFG,  7'd3,   gwct_pkg::DIR_Y_UP, 1'b0, 14'd0, 14'd0},
        '{ROW_STEP, 7'd0,   gwct_pkg::DIR_X_DN, 1'b0, 14'd0, 14'd0},
        '{ROW_STEP, 7'd0,   gwct_pkg::DIR_X_DN, 1'b0, 14'd0, 14'd0},
        '{ROW_STEP, 7'd0,   gwct_pkg::DIR_X_DN, 1'b1, 14'd3, 14'd25},
        '{ROW_STEP, 7'd0,   gwct_pkg::DIR_Y_DN, 1'b0, 14'd0, 14'd0},
        '{ROW_STEP, 7'd0,   gwct_pkg::DIR_Y_DN, 1'b0, 14'd0, 14'd0},
        '{ROW_STEP, 7'd0,   gwct_pkg::DIR_Y_DN, 1'b1, 14'd3, 14'd25}
    };

    logic                        i_clk = 1'b0;
    logic                        i_rst_n;
    logic                        i_cfg_wr_en;
    logic [gwct_pkg::HALF_W-1:0] i_cfg_wr_data;

    gwct_step_if   step_if ();
    gwct_result_if result_if ();

    grid_walk_coverage_tracker i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_step        (step_if),
        .o_result      (result_if)
    );

    // Walk model state
    logic [gwct_pkg::HALF_W-1:0]       half_reg;
    logic signed [gwct_pkg::POS_W-1:0] walk_x;
    logic signed [gwct_pkg::POS_W-1:0] walk_y;
    logic [gwct_pkg::CNT_W-1:0]        marked_count;
    bit cell_seen [0:gwct_pkg::SIDE-1][0:gwct_pkg::SIDE-1];

    t_walk_report pending_reports [$];

    int  sender_idle_pct;
    int  recv_stall_pct;
    int  quiet_cycles;
    int  fail_count;
    int  steps_sent;
    int  walks_done;
    bit  last_step_escaped;

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    function automatic void note_failure(input string what);
        fail_count++;
        if (fail_count <= 10) begin
            $display("%s", what);
        end
    endfunction

    function automatic bit in_grid(input int x, input int y, input int n);
        return (x > -n) && (x < n) && (y > -n) && (y < n);
    endfunction

    function automatic void restart_walk();
        cell_seen    = '{default: 1'b0};
        marked_count = '0;
        walk_x       = '0;
        walk_y       = '0;
    endfunction

    // One step of the walk; returns 1 when the step ends the walk
    function automatic bit predict_step(input gwct_pkg::t_dir d, output t_walk_report rep);
        int n;
        int x;
        int y;
        n = int'(half_reg);
        if (n < 1) n = 1;
        if (n > gwct_pkg::MAX_HALF) n = gwct_pkg::MAX_HALF;
        x = walk_x;
        y = walk_y;
        rep.grid    = gwct_pkg::CNT_W'((2 * n - 1) * (2 * n - 1));
        rep.visited = '0;
        // already outside after a shrink: report, no mark, no move
        if (!in_grid(x, y, n)) begin
            rep.visited = marked_count;
            restart_walk();
            return 1'b1;
        end
        if (!cell_seen[x + gwct_pkg::MAX_HALF - 1][y + gwct_pkg::MAX_HALF - 1]) begin
            cell_seen[x + gwct_pkg::MAX_HALF - 1][y + gwct_pkg::MAX_HALF - 1] = 1'b1;
            marked_count++;
        end
        case (d)
            gwct_pkg::DIR_Y_UP: y++;
            gwct_pkg::DIR_X_UP: x++;
            gwct_pkg::DIR_Y_DN: y--;
            default:            x--;
        endcase
        walk_x = gwct_pkg::POS_W'(x);
        walk_y = gwct_pkg::POS_W'(y);
        if (!in_grid(x, y, n)) begin
            rep.visited = marked_count;
            restart_walk();
            return 1'b1;
        end
        return 1'b0;
    endfunction

    task automatic set_idle_mode(input t_idle_mode m);
        case (m)
            IDLE_SENDER:   begin sender_idle_pct = 69; recv_stall_pct = 0;  end
            IDLE_RECEIVER: begin sender_idle_pct = 0;  recv_stall_pct = 69; end
            IDLE_BOTH:     begin sender_idle_pct = 18; recv_stall_pct = 18; end
            default:       begin sender_idle_pct = 0;  recv_stall_pct = 0;  end
        endcase
    endtask

    // Send one step request and record the report it should cause
    task automatic issue_step(input gwct_pkg::t_dir d, input bit typed,
                              input t_walk_report want);
        t_walk_report got;
        bit           hit;
        if (sender_idle_pct != 0 && $urandom_range(0, 99) < sender_idle_pct) begin
            step_if.valid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(0, 99) < sender_idle_pct);
        end
        step_if.valid     <= 1'b1;
        step_if.direction <= d;
        do @(posedge i_clk); while (!step_if.ready);
        hit = predict_step(d, got);
        if (typed) begin
            pending_reports.push_back(want);
        end else if (hit) begin
            pending_reports.push_back(got);
        end
        last_step_escaped = hit;
        steps_sent++;
        if (hit) walks_done++;
    endtask

    task automatic hold_until_drained();
        step_if.valid <= 1'b0;
        do @(posedge i_clk); while (pending_reports.size() != 0);
    endtask

    // Register write while idle; an escape leaves a map sweep running
    task automatic write_half(input logic [gwct_pkg::HALF_W-1:0] value);
        hold_until_drained();
        repeat (last_step_escaped ? SWEEP_CYCLES + 32 : 4) @(posedge i_clk);
        last_step_escaped = 1'b0;
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= value;
        @(posedge i_clk);
        i_cfg_wr_en   <= 1'b0;
        half_reg = value;
    endtask

    // Report channel: random stall, compare, watchdog count
    always @(posedge i_clk) begin : report_check
        t_walk_report want;
        result_if.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
        if (i_rst_n && result_if.valid && result_if.ready) begin
            if (pending_reports.size() == 0) begin
                note_failure($sformatf("unexpected report: visited %0d grid %0d",
                                       result_if.visited_cells, result_if.grid_cells));
            end else begin
                want = pending_reports.pop_front();
                if (want.visited !== result_if.visited_cells ||
                    want.grid !== result_if.grid_cells) begin
                    note_failure($sformatf(
                        "report mismatch: expected visited %0d grid %0d, got %0d / %0d",
                        want.visited, want.grid,
                        result_if.visited_cells, result_if.grid_cells));
                end
            end
        end
        if ((step_if.valid && step_if.ready) || (result_if.valid && result_if.ready)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
        end
    end

    initial begin : watchdog
        wait (quiet_cycles >= WATCHDOG_LIMIT);
        $display("grid_walk_coverage_tracker_tb failed");
        $finish;
    end

    initial begin : stimulus
        int             phase;
        int             count;
        int             drift_pct;
        int             walks_before;
        int             steps_left;
        gwct_pkg::t_dir drift;
        gwct_pkg::t_dir d;
        t_idle_mode     phase_mode;

        step_if.valid     = 1'b0;
        step_if.direction = gwct_pkg::DIR_Y_UP;
        result_if.ready   = 1'b0;
        i_cfg_wr_en       = 1'b0;
        i_cfg_wr_data     = '0;
        i_rst_n           = 1'b0;
        quiet_cycles      = 0;
        fail_count        = 0;
        steps_sent        = 0;
        walks_done        = 0;
        last_step_escaped = 1'b0;
        half_reg          = gwct_pkg::HALF_W'(gwct_pkg::MAX_HALF);
        restart_walk();
        set_idle_mode(IDLE_NONE);

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed table
        for (int r = 0; r < PLAN_ROWS; r++) begin
            if (DIRECTED_PLAN[r].kind == ROW_CFG) begin
                write_half(DIRECTED_PLAN[r].half);
            end else begin
                issue_step(DIRECTED_PLAN[r].dir, DIRECTED_PLAN[r].typed,
                           {DIRECTED_PLAN[r].want_visited, DIRECTED_PLAN[r].want_grid});
            end
        end

        // Random walks: small grids with a per-phase drift, one long full-size walk
        phase = 0;
        while ((steps_sent < STEP_TARGET || walks_done < WALK_TARGET) &&
               walks_done < WALK_CAP) begin
            phase_mode = t_idle_mode'(phase % 4);
            set_idle_mode(phase_mode);
            if (phase == 2) begin
                write_half(gwct_pkg::HALF_W'(gwct_pkg::MAX_HALF));
                walks_before = walks_done;
                steps_left   = 400;
                while (walks_done == walks_before && steps_left > 0) begin
                    d = ($urandom_range(0, 99) < 85) ? gwct_pkg::DIR_X_UP
                                                     : gwct_pkg::t_dir'($urandom_range(0, 3));
                    issue_step(d, 1'b0, '0);
                    steps_left--;
                end
            end else begin
                write_half(gwct_pkg::HALF_W'($urandom_range(2, 6)));
                drift     = gwct_pkg::t_dir'($urandom_range(0, 3));
                drift_pct = $urandom_range(0, 50);
                count     = $urandom_range(20, 60);
                repeat (count) begin
                    // occasional full drain before the next request
                    if (phase_mode == IDLE_BOTH && $urandom_range(0, 15) == 0) begin
                        hold_until_drained();
                    end
                    d = ($urandom_range(0, 99) < drift_pct)
                        ? drift : gwct_pkg::t_dir'($urandom_range(0, 3));
                    issue_step(d, 1'b0, '0);
                end
            end
            phase++;
        end

        hold_until_drained();
        repeat (END_SETTLE) @(posedge i_clk);
        if (pending_reports.size() != 0) begin
            note_failure($sformatf("%0d expected reports never arrived",
                                   pending_reports.size()));
        end

        $display("Covered %0d step requests, %0d finished walks, half sizes 0 to 127",
                 steps_sent, walks_done);
        $display("Failures seen: %0d", fail_count);
        if (fail_count == 0) begin
            $display("grid_walk_coverage_tracker_tb passed");
        end else begin
            $display("grid_walk_coverage_tracker_tb failed");
        end
        $finish;
    end

endmodule
